// ===== rtl/kct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kct_pkg: shared definitions for the keyed counter table
// Sizes, operation and status codes, and the controller command bundle.
// ----------------------------------------------------------------------------
package kct_pkg;

  localparam int ENTRIES  = 64;  // table slots, 2 to 1024
  localparam int KEY_BITS = 16;  // significant key bits, 4 to 32
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [IDX_W-1:0]    idx_t;

  // operation codes
  localparam logic [2:0] KIND_ADD    = 3'd0;
  localparam logic [2:0] KIND_SUB    = 3'd1;
  localparam logic [2:0] KIND_REMOVE = 3'd2;
  localparam logic [2:0] KIND_QUERY  = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  // result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_KEY    = 3'd1;
  localparam logic [2:0] ST_ZERO_DELTA = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_OVERFLOW   = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic load_op;  // capture request and match/free vectors
    logic read;     // encode slot indices, read stored count
    logic update;   // modify table, load result register
  } cmd_t;

endpackage

// ===== rtl/kct_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kct_ctrl: sequencing for the keyed counter table
// Three-step state machine and the result valid flag.
// ----------------------------------------------------------------------------
module kct_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output kct_pkg::cmd_t cmd
);
  import kct_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_UPDATE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next  = state;
    cmd.load_op = 1'b0;
    cmd.read    = 1'b0;
    cmd.update  = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_op = 1'b1;
          state_next  = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        // hold until the result register can take the new transaction
        if (out_free) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.update) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/kct_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kct_dp: datapath of the keyed counter table
// Key registers with parallel compare, valid bits, count memory,
// slot encoders, add/subtract with overflow check and result register.
// ----------------------------------------------------------------------------
module kct_dp (
  input  logic               clk,
  input  logic               rst,
  input  kct_pkg::cmd_t      cmd,
  input  logic [2:0]         kind,
  input  logic [15:0]        key,
  input  logic signed [31:0] delta,
  output logic signed [31:0] count,
  output logic               found,
  output logic [2:0]         status
);
  import kct_pkg::*;

  key_t               keys [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [31:0]        mem  [ENTRIES];

  key_t               key_in;
  logic [ENTRIES-1:0] match_next;

  logic [2:0]         op_kind;
  key_t               op_key;
  logic signed [31:0] op_delta;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] free_vec;

  idx_t               hit_idx_c;
  idx_t               free_idx_c;
  idx_t               hit_idx;
  idx_t               free_idx;
  logic               hit;
  logic               free_any;
  logic [31:0]        rd_count;

  logic [32:0]        sum;
  logic               ovf;
  logic               clr_all;
  logic               clr_one;
  logic               set_one;
  logic               mem_we;
  idx_t               mem_addr;
  logic [31:0]        mem_wdata;
  logic signed [31:0] count_next;
  logic               found_next;
  logic [2:0]         status_next;

  assign key_in = key_t'(key);

  // parallel compare against every stored key
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_next[i] = valid[i] && (keys[i] == key_in);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_op) begin
      op_kind  <= kind;
      op_key   <= key_in;
      op_delta <= delta;
      match    <= match_next;
      free_vec <= ~valid;
    end
  end

  // keys are unique, so the match index is a plain OR of positions
  always_comb begin
    hit_idx_c = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) hit_idx_c = hit_idx_c | idx_t'(i);
    end
  end

  // lowest free slot
  always_comb begin
    free_idx_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (free_vec[i]) free_idx_c = idx_t'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      hit_idx  <= hit_idx_c;
      free_idx <= free_idx_c;
      hit      <= |match;
      free_any <= |free_vec;
      rd_count <= mem[hit_idx_c];
    end
  end

  // 33-bit signed result; overflow when the top two bits differ
  assign sum = (op_kind == KIND_ADD)
             ? {rd_count[31], rd_count} + {op_delta[31], op_delta}
             : {rd_count[31], rd_count} - {op_delta[31], op_delta};
  assign ovf = sum[32] ^ sum[31];

  always_comb begin
    clr_all     = 1'b0;
    clr_one     = 1'b0;
    set_one     = 1'b0;
    mem_we      = 1'b0;
    mem_addr    = hit_idx;
    mem_wdata   = sum[31:0];
    count_next  = '0;
    found_next  = 1'b0;
    status_next = ST_OK;
    if (op_kind == KIND_CLEAR) begin
      clr_all = 1'b1;
    end else if (op_kind <= KIND_QUERY) begin
      if (op_key == '0) begin
        status_next = ST_BAD_KEY;
      end else if ((op_kind == KIND_ADD || op_kind == KIND_SUB) && op_delta == '0) begin
        status_next = ST_ZERO_DELTA;
      end else begin
        found_next = hit;
        case (op_kind)
          KIND_ADD, KIND_SUB: begin
            if (hit) begin
              if (ovf) begin
                status_next = ST_OVERFLOW;
                count_next  = rd_count;
              end else if (sum[31:0] == '0) begin
                clr_one = 1'b1;
              end else begin
                mem_we     = 1'b1;
                count_next = sum[31:0];
              end
            end else if (op_kind == KIND_ADD) begin
              if (!free_any) begin
                status_next = ST_FULL;
              end else begin
                set_one    = 1'b1;
                mem_we     = 1'b1;
                mem_addr   = free_idx;
                mem_wdata  = op_delta;
                count_next = op_delta;
              end
            end
          end
          KIND_REMOVE: clr_one = hit;
          KIND_QUERY: begin
            if (hit) count_next = rd_count;
          end
          default: count_next = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.update) begin
      if (clr_all) begin
        valid <= '0;
      end else if (clr_one) begin
        valid[hit_idx] <= 1'b0;
      end else if (set_one) begin
        valid[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && set_one) begin
      keys[free_idx] <= op_key;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update && mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      count  <= count_next;
      found  <= found_next;
      status <= status_next;
    end
  end

endmodule

// ===== rtl/keyed_counter_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_counter_table: table of unique keys with signed 32-bit counts
// Add, subtract, remove, query and clear, one result per transaction.
// ----------------------------------------------------------------------------
// Each request transaction yields exactly one response transaction. The
// table holds 64 slots; keys live in flip-flops and are all compared at
// once in the cycle the request is taken, the counts sit in a one-port
// memory. A request then goes through three steps: capture and key compare,
// slot encoding with the count memory read, and the update that writes the
// table and loads the response register. The response is valid once the
// update step has loaded it, and a new request is accepted only after the
// controller returns to idle, so one transaction is in work at a time; the
// count memory read between the compare and the adder takes its own step.
// The response register decouples the sides: the next request is taken
// while a response still waits, and only the update step waits on a stalled
// response. Add inserts into the lowest free slot when the key is absent; a
// count reaching zero frees its slot. Key 0 is rejected with status 1, a
// zero delta on add or subtract with status 2, an insert into a full table
// with status 3, and a count leaving the 32-bit signed range with status 4
// (the slot keeps its old count, which is returned). Clear and the unused
// kind codes 5 to 7 answer zero with status 0. Reset empties the table by
// clearing every valid bit at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module keyed_counter_table (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [2:0]         kind,
  input  logic [15:0]        key,
  input  logic signed [31:0] delta,
  // response channel
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic signed [31:0] count,
  output logic               found,
  output logic [2:0]         status
);
  import kct_pkg::*;

  cmd_t cmd;

  // sequencing: capture, read, update
  kct_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  // table storage, compare, arithmetic and response register
  kct_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .kind   (kind),
    .key    (key),
    .delta  (delta),
    .count  (count),
    .found  (found),
    .status (status)
  );

endmodule

// ===== rtl/kct_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kct_checker: port-level checks for the keyed counter table
// Watches both channels of the top level; attached by bind.
// ----------------------------------------------------------------------------
module kct_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input logic signed [31:0] count,
  input logic               found,
  input logic [2:0]         status
);
  import kct_pkg::*;

  // a taken request keeps the port busy for its two working steps
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (req_stall ##1 req_stall))
    else $error("request port free too early");

  // a new response only appears while a transaction is in work
  a_rsp_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response without a transaction in work");

  // rejected transactions carry no count and no hit
  a_reject_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (status == ST_BAD_KEY || status == ST_ZERO_DELTA ||
                   status == ST_FULL)) |-> (count == '0 && !found))
    else $error("rejected transaction with count or found");

  // overflow only happens on a key that was held
  a_ovf_found: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status == ST_OVERFLOW) |-> found)
    else $error("overflow without a matching key");

  // a stalled response stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(count) &&
                                  $stable(found) && $stable(status)))
    else $error("stalled response changed");

endmodule

bind keyed_counter_table kct_checker u_kct_checker (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for keyed_counter_table
// Drives add, subtract, remove, query and clear transactions through the
// valid/stall request channel and compares every response against an
// answer written out in the script or a behavioural copy of the table. A
// short scripted run covers the corner cases, a table fill exercises the
// full status, and randomised traffic under three idling schemes follows.
// ----------------------------------------------------------------------------
module tb;
  import kct_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;  // generous ceiling for ~2100 transactions
  localparam int RANDOM_ITEMS = 2000;
  localparam int DRAIN_CYCLES = 12;      // response lands after the read and update steps
  localparam int MAX_SHOWN    = 10;
  localparam int SCRIPT_LEN   = 29;

  // kind codes the block accepts but ignores
  localparam logic [2:0] KIND_UNUSED_5 = 3'd5;
  localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
  localparam logic [2:0] KIND_UNUSED_7 = 3'd7;

  localparam logic signed [31:0] CNT_TOP    = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] CNT_BOTTOM = 32'sh8000_0000;
  localparam longint             WIDE_TOP   = 64'sd2147483647;
  localparam longint             WIDE_BOTTOM = -64'sd2147483648;

  // one response transaction
  typedef struct packed {
    logic signed [31:0] count;
    logic               found;
    logic [2:0]         status;
  } answer_t;

  // one scripted request; 'typed' marks rows whose answer is written out
  typedef struct packed {
    logic [2:0]         kind;
    logic [15:0]        key;
    logic signed [31:0] delta;
    logic               typed;
    answer_t            want;
  } row_t;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [2:0]         kind      = KIND_QUERY;
  logic [15:0]        key       = '0;
  logic signed [31:0] delta     = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic signed [31:0] count;
  logic               found;
  logic [2:0]         status;

  keyed_counter_table uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .kind      (kind),
    .key       (key),
    .delta     (delta),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .count     (count),
    .found     (found),
    .status    (status)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Shadow table: slot contents as the block should hold them
  // --------------------------------------------------------------------------
  key_t               shadow_key   [ENTRIES];
  logic signed [31:0] shadow_count [ENTRIES];
  bit                 shadow_used  [ENTRIES];

  answer_t owed_answers [$];   // answers for accepted requests, oldest first
  int      faults       = 0;
  int      cycles       = 0;
  int      tx_idle_pct  = 0;   // chance per cycle that the request side idles
  int      rx_stall_pct = 0;   // chance per cycle that the response side stalls
  answer_t owed;

  // Applies one request to the shadow table and returns the answer it earns.
  // Key 0 is rejected before the zero delta test; an overflowing count is
  // left alone and its old value returned; a count reaching zero frees its slot.
  function automatic answer_t apply_counter_op(input logic [2:0] op,
                                               input logic [15:0] key_in,
                                               input logic signed [31:0] amt);
    answer_t ans;
    key_t    k;
    int      hit;
    int      spare;
    longint  wide;
    ans   = '0;
    k     = key_t'(key_in);
    hit   = -1;
    spare = -1;
    if (op == KIND_CLEAR) begin
      foreach (shadow_used[i]) shadow_used[i] = 1'b0;
    end else if (op <= KIND_QUERY) begin
      if (k == '0) begin
        ans.status = ST_BAD_KEY;
      end else if ((op == KIND_ADD || op == KIND_SUB) && amt == 0) begin
        ans.status = ST_ZERO_DELTA;
      end else begin
        for (int i = ENTRIES - 1; i >= 0; i--) begin
          if (shadow_used[i] && shadow_key[i] == k) hit = i;
          if (!shadow_used[i]) spare = i;   // ends on the lowest free slot
        end
        ans.found = (hit >= 0);
        case (op)
          KIND_ADD, KIND_SUB: begin
            if (hit >= 0) begin
              wide = (op == KIND_ADD) ? longint'(shadow_count[hit]) + longint'(amt)
                                      : longint'(shadow_count[hit]) - longint'(amt);
              if (wide > WIDE_TOP || wide < WIDE_BOTTOM) begin
                ans.status = ST_OVERFLOW;
                ans.count  = shadow_count[hit];
              end else if (wide == 0) begin
                shadow_used[hit] = 1'b0;
              end else begin
                shadow_count[hit] = wide[31:0];
                ans.count         = wide[31:0];
              end
            end else if (op == KIND_ADD) begin
              if (spare < 0) begin
                ans.status = ST_FULL;
              end else begin
                shadow_used[spare]  = 1'b1;
                shadow_key[spare]   = k;
                shadow_count[spare] = amt;
                ans.count           = amt;
              end
            end
          end
          KIND_REMOVE: begin
            if (hit >= 0) shadow_used[hit] = 1'b0;
          end
          default: begin   // query
            if (hit >= 0) ans.count = shadow_count[hit];
          end
        endcase
      end
    end
    return ans;
  endfunction

  task automatic log_fault(input string msg);
    faults++;
    if (faults <= MAX_SHOWN) $display("%0t ns: %s", $time, msg);
  endtask

  // --------------------------------------------------------------------------
  // Request side. Called at a falling edge; returns at the falling edge after
  // the transaction is taken. req_valid is not lowered on the way out, so the
  // next call sets it once per step whether it idles first or not.
  // --------------------------------------------------------------------------
  task automatic issue_request(input logic [2:0] op, input logic [15:0] k,
                               input logic signed [31:0] d,
                               input logic typed, input answer_t want);
    answer_t model;
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      kind      <= 3'($urandom);   // payload is free while idle
      @(negedge clk);
    end
    req_valid <= 1'b1;
    kind      <= op;
    key       <= k;
    delta     <= d;
    do @(posedge clk); while (req_stall);
    // accepted at this edge: the shadow table moves on regardless, the
    // scripted answer wins where one was written out
    model = apply_counter_op(op, k, d);
    owed_answers.push_back(typed ? want : model);
    @(negedge clk);
  endtask

  // response side back-pressure
  always @(negedge clk) rsp_stall <= ($urandom_range(99) < rx_stall_pct);

  // --------------------------------------------------------------------------
  // Response checker, sampling at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycles++;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (owed_answers.size() == 0) begin
        log_fault($sformatf("response with nothing owed: count %0d found %0b status %0d",
                            count, found, status));
      end else begin
        owed = owed_answers.pop_front();
        if (count !== owed.count || found !== owed.found || status !== owed.status)
          log_fault($sformatf("mismatch: expected count %0d found %0b status %0d, got count %0d found %0b status %0d",
                              owed.count, owed.found, owed.status, count, found, status));
      end
    end
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Scripted corner cases
  // --------------------------------------------------------------------------
  row_t script [0:SCRIPT_LEN-1] = '{
    // empty table after reset
    '{KIND_QUERY,  16'h0005, 32'sd0,  1'b1, '{32'sd0, 1'b0, ST_OK}},
    // key 0 is refused for every keyed operation, ahead of a zero delta
    '{KIND_ADD,    16'h0000, 32'sd7,  1'b1, '{32'sd0, 1'b0, ST_BAD_KEY}},
    '{KIND_SUB,    16'h0000, 32'sd7,  1'b1, '{32'sd0, 1'b0, ST_BAD_KEY}},
    '{KIND_REMOVE, 16'h0000, 32'sd0,  1'b1, '{32'sd0, 1'b0, ST_BAD_KEY}},
    '{KIND_QUERY,  16'h0000, 32'sd0,  1'b1, '{32'sd0, 1'b0, ST_BAD_KEY}},
    '{KIND_ADD,    16'h0000, 32'sd0,  1'b1, '{32'sd0, 1'b0, ST_BAD_KEY}},
    // zero delta
    '{KIND_ADD,    16'h0005, 32'sd0,  1'b1, '{32'sd0, 1'b0, ST_ZERO_DELTA}},
    '{KIND_SUB,    16'h0005, 32'sd0,  1'b1, '{32'sd0, 1'b0, ST_ZERO_DELTA}},
    // subtract from an absent key is a quiet no-op
    '{KIND_SUB,    16'h0009, 32'sd3,  1'b1, '{32'sd0, 1'b0, ST_OK}},
    // top of range, then both directions of overflow
    '{KIND_ADD,    16'hFFFF, CNT_TOP, 1'b1, '{CNT_TOP, 1'b0, ST_OK}},
    '{KIND_ADD,    16'hFFFF, 32'sd1,  1'b1, '{CNT_TOP, 1'b1, ST_OVERFLOW}},
    '{KIND_SUB,    16'hFFFF, -32'sd1, 1'b1, '{CNT_TOP, 1'b1, ST_OVERFLOW}},
    '{KIND_ADD,    16'h0001, CNT_BOTTOM, 1'b1, '{CNT_BOTTOM, 1'b0, ST_OK}},
    '{KIND_SUB,    16'h0001, 32'sd1,  1'b1, '{CNT_BOTTOM, 1'b1, ST_OVERFLOW}},
    '{KIND_ADD,    16'h0001, -32'sd1, 1'b1, '{CNT_BOTTOM, 1'b1, ST_OVERFLOW}},
    // counts reaching zero free their slots
    '{KIND_SUB,    16'h0001, CNT_BOTTOM, 1'b1, '{32'sd0, 1'b1, ST_OK}},
    '{KIND_QUERY,  16'h0001, 32'sd0,  1'b1, '{32'sd0, 1'b0, ST_OK}},
    '{KIND_ADD,    16'hFFFF, 32'sh8000_0001, 1'b1, '{32'sd0, 1'b1, ST_OK}},
    // ordinary traffic, then remove present and absent
    '{KIND_ADD,    16'h0003, 32'sd10, 1'b0, '0},
    '{KIND_SUB,    16'h0003, 32'sd4,  1'b0, '0},
    '{KIND_QUERY,  16'h0003, 32'sd0,  1'b0, '0},
    '{KIND_REMOVE, 16'h0003, 32'sd0,  1'b1, '{32'sd0, 1'b1, ST_OK}},
    '{KIND_REMOVE, 16'h0003, 32'sd0,  1'b1, '{32'sd0, 1'b0, ST_OK}},
    // spare kind codes answer zero
    '{KIND_UNUSED_5, 16'hAAAA, 32'sh5555_5555, 1'b1, '{32'sd0, 1'b0, ST_OK}},
    '{KIND_UNUSED_6, 16'h5555, -32'sd1, 1'b1, '{32'sd0, 1'b0, ST_OK}},
    '{KIND_UNUSED_7, 16'h0000, 32'sd0,  1'b1, '{32'sd0, 1'b0, ST_OK}},
    // clear ignores key and delta and empties the table
    '{KIND_ADD,    16'h8000, 32'sh4000_0000, 1'b0, '0},
    '{KIND_CLEAR,  16'h1234, 32'sd42, 1'b1, '{32'sd0, 1'b0, ST_OK}},
    '{KIND_QUERY,  16'h8000, 32'sd0,  1'b1, '{32'sd0, 1'b0, ST_OK}}
  };

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [2:0]         r_kind;
    logic [15:0]        r_key;
    logic signed [31:0] r_delta;
    int                 pick;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // first idling scheme covers the script, the fill and a third of the random run
    tx_idle_pct  = 11;
    rx_stall_pct = 57;

    foreach (script[i])
      issue_request(script[i].kind, script[i].key, script[i].delta,
                    script[i].typed, script[i].want);

    // fill every slot, then one more insert must be refused as table full
    for (int i = 1; i <= ENTRIES; i++)
      issue_request(KIND_ADD, 16'(i * 37), 32'(i), 1'b0, '0);
    issue_request(KIND_ADD, 16'hBEEF, 32'sd1, 1'b0, '0);
    issue_request(KIND_QUERY, 16'(37), 32'sd0, 1'b0, '0);
    // free one slot and insert into it
    issue_request(KIND_SUB, 16'(5 * 37), 32'sd5, 1'b0, '0);
    issue_request(KIND_ADD, 16'hBEEF, 32'sd1, 1'b0, '0);
    issue_request(KIND_CLEAR, 16'h0000, 32'sd0, 1'b0, '0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 11; rx_stall_pct = 57; end
        1: begin tx_idle_pct = 57; rx_stall_pct = 11; end
        default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
      endcase
      repeat (RANDOM_ITEMS / 3) begin
        // add-heavy mix so the table fills now and then; clear is rare
        pick = $urandom_range(199);
        if (pick < 70)       r_kind = KIND_ADD;
        else if (pick < 110) r_kind = KIND_SUB;
        else if (pick < 130) r_kind = KIND_REMOVE;
        else if (pick < 175) r_kind = KIND_QUERY;
        else if (pick < 176) r_kind = KIND_CLEAR;
        else if (pick < 182) r_kind = 3'($urandom_range(KIND_UNUSED_5, KIND_UNUSED_7));
        else                 r_kind = KIND_ADD;

        // a small pool gives many hits and overflow chances, a wider one fills
        // the table, and a few keys span all 16 bits
        pick = $urandom_range(99);
        if (pick < 4)       r_key = '0;
        else if (pick < 50) r_key = 16'($urandom_range(1, 12));
        else if (pick < 90) r_key = 16'($urandom_range(1, 90));
        else                r_key = 16'($urandom);

        pick = $urandom_range(99);
        if (pick < 5) begin
          r_delta = '0;
        end else if (pick < 17) begin
          case ($urandom_range(5))
            0: r_delta = CNT_TOP;
            1: r_delta = CNT_BOTTOM;
            2: r_delta = CNT_TOP - 1;
            3: r_delta = CNT_BOTTOM + 1;
            4: r_delta = -32'sd1;
            default: r_delta = 32'sd1;
          endcase
        end else if (pick < 70) begin
          r_delta = int'($urandom_range(0, 40)) - 20;
        end else begin
          r_delta = 32'($urandom);
        end

        issue_request(r_kind, r_key, r_delta, 1'b0, '0);
      end
    end

    req_valid <= 1'b0;
    while (owed_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (faults == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== keyed_counter_table.f =====
rtl/kct_pkg.sv
rtl/kct_ctrl.sv
rtl/kct_dp.sv
rtl/keyed_counter_table.sv
rtl/kct_checker.sv
bench/tb.sv
